/* hdl/idr_pkg.sv */
package idr_pkg;

  localparam int MODE_W = 4;
  localparam int ROW_W = 2;
  localparam int COEF_W = 15;
  localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN = -(1 << (COEF_W - 1));
  localparam int LAST_ROW = 3;

endpackage

/* hdl/idr_row_if.sv */
interface idr_row_if #(parameter int PIXEL_BITS = 8);
  import idr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] cur_0;
  logic [PIXEL_BITS-1:0] cur_1;
  logic [PIXEL_BITS-1:0] cur_2;
  logic [PIXEL_BITS-1:0] cur_3;
  logic [PIXEL_BITS-1:0] pred_0;
  logic [PIXEL_BITS-1:0] pred_1;
  logic [PIXEL_BITS-1:0] pred_2;
  logic [PIXEL_BITS-1:0] pred_3;
  logic [MODE_W-1:0]     mode_tag;

  modport source (
    output valid, cur_0, cur_1, cur_2, cur_3, pred_0, pred_1, pred_2, pred_3, mode_tag,
    input  ready
  );
  modport sink (
    input  valid, cur_0, cur_1, cur_2, cur_3, pred_0, pred_1, pred_2, pred_3, mode_tag,
    output ready
  );

endinterface

/* hdl/idr_coef_if.sv */
interface idr_coef_if;
  import idr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_0;
  logic signed [COEF_W-1:0] coef_1;
  logic signed [COEF_W-1:0] coef_2;
  logic signed [COEF_W-1:0] coef_3;
  logic [ROW_W-1:0]         out_row;
  logic [MODE_W-1:0]        out_mode;
  logic                     last_row;

  modport source (
    output valid, coef_0, coef_1, coef_2, coef_3, out_row, out_mode, last_row,
    input  ready
  );
  modport sink (
    input  valid, coef_0, coef_1, coef_2, coef_3, out_row, out_mode, last_row,
    output ready
  );

endinterface

/* hdl/idr_front.sv */
module idr_front #(
  parameter int PIXEL_BITS = 8,
  parameter int QW = 4 * (PIXEL_BITS + 1) + idr_pkg::ROW_W + idr_pkg::MODE_W
) (
  input  logic          clk,
  input  logic          rst,
  idr_row_if.sink       rows,
  output logic [QW-1:0] q_data,
  output logic          q_valid,
  input  logic          q_ready
);
  import idr_pkg::*;

  localparam int RW = PIXEL_BITS + 1;

  logic [ROW_W-1:0]  row_cnt;
  logic [MODE_W-1:0] held_mode;
  logic [MODE_W-1:0] word_mode;
  logic              accept;
  logic signed [RW-1:0] r0, r1, r2, r3;

  assign rows.ready = q_ready;
  assign q_valid = rows.valid;
  assign accept = rows.valid && q_ready;

  // residuals in one bit more than a pixel
  assign r0 = $signed({1'b0, rows.cur_0}) - $signed({1'b0, rows.pred_0});
  assign r1 = $signed({1'b0, rows.cur_1}) - $signed({1'b0, rows.pred_1});
  assign r2 = $signed({1'b0, rows.cur_2}) - $signed({1'b0, rows.pred_2});
  assign r3 = $signed({1'b0, rows.cur_3}) - $signed({1'b0, rows.pred_3});

  // the tag of the block's first row holds for the whole block
  assign word_mode = (row_cnt == '0) ? rows.mode_tag : held_mode;
  assign q_data = {word_mode, row_cnt, r3, r2, r1, r0};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      held_mode <= '0;
    end else if (accept) begin
      row_cnt <= row_cnt + 1'b1;
      if (row_cnt == '0) begin
        held_mode <= rows.mode_tag;
      end
    end
  end

endmodule

/* hdl/idr_queue.sv */
module idr_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] in_data,
  input  logic             in_valid,
  output logic             in_ready,
  output logic [WIDTH-1:0] out_data,
  output logic             out_valid,
  input  logic             out_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             push;
  logic             pop;

  assign in_ready = (cnt != CW'(DEPTH));
  assign out_valid = (cnt != '0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

/* hdl/idr_back.sv */
module idr_back #(
  parameter int PIXEL_BITS = 8,
  parameter int QW = 4 * (PIXEL_BITS + 1) + idr_pkg::ROW_W + idr_pkg::MODE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [QW-1:0] q_data,
  input  logic          q_valid,
  output logic          q_ready,
  idr_coef_if.source    coefs
);
  import idr_pkg::*;

  localparam int RW = PIXEL_BITS + 1;
  localparam int TW = RW + 3;
  localparam int YW = TW + 3;
  localparam logic signed [YW-1:0] YMAX = YW'(COEF_MAX);
  localparam logic signed [YW-1:0] YMIN = YW'(COEF_MIN);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t state;
  logic [ROW_W-1:0]  cnt;
  logic [MODE_W-1:0] mode_hold;
  logic signed [RW-1:0] d [3][4];
  logic signed [TW-1:0] t [4][4];
  logic signed [TW-1:0] t_next [4][4];
  logic signed [YW-1:0] y [4];
  logic signed [RW-1:0] q_res [4];
  logic [ROW_W-1:0]  q_row;
  logic [MODE_W-1:0] q_mode;
  logic              pop;
  logic              out_load;

  function automatic logic signed [COEF_W-1:0] sat(input logic signed [YW-1:0] v);
    if (v > YMAX) begin
      return COEF_W'(COEF_MAX);
    end else if (v < YMIN) begin
      return COEF_W'(COEF_MIN);
    end
    return COEF_W'(v);
  endfunction

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      q_res[j] = q_data[j*RW +: RW];
    end
  end
  assign q_row = q_data[4*RW +: ROW_W];
  assign q_mode = q_data[4*RW+ROW_W +: MODE_W];

  assign q_ready = (state == ST_LOAD);
  assign pop = q_valid && q_ready;
  assign out_load = (state == ST_EMIT) && (!coefs.valid || coefs.ready);

  // column pass, the last row comes straight from the queue
  always_comb begin
    logic signed [TW-1:0] a0, a1, a2, a3, s0, s1, e0, e1;
    for (int j = 0; j < 4; j++) begin
      a0 = TW'(d[0][j]);
      a1 = TW'(d[1][j]);
      a2 = TW'(d[2][j]);
      a3 = TW'(q_res[j]);
      s0 = a0 + a3;
      s1 = a1 + a2;
      e0 = a0 - a3;
      e1 = a1 - a2;
      t_next[0][j] = s0 + s1;
      t_next[1][j] = (e0 <<< 1) + e1;
      t_next[2][j] = s0 - s1;
      t_next[3][j] = e0 - (e1 <<< 1);
    end
  end

  // row pass on one row of t per output word
  always_comb begin
    logic signed [YW-1:0] b0, b1, b2, b3, s0, s1, e0, e1;
    b0 = YW'(t[cnt][0]);
    b1 = YW'(t[cnt][1]);
    b2 = YW'(t[cnt][2]);
    b3 = YW'(t[cnt][3]);
    s0 = b0 + b3;
    s1 = b1 + b2;
    e0 = b0 - b3;
    e1 = b1 - b2;
    y[0] = s0 + s1;
    y[1] = (e0 <<< 1) + e1;
    y[2] = s0 - s1;
    y[3] = e0 - (e1 <<< 1);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_row == ROW_W'(LAST_ROW)) begin
        t <= t_next;
        mode_hold <= q_mode;
      end else begin
        d[q_row] <= q_res;
      end
    end
    if (out_load) begin
      coefs.coef_0 <= sat(y[0]);
      coefs.coef_1 <= sat(y[1]);
      coefs.coef_2 <= sat(y[2]);
      coefs.coef_3 <= sat(y[3]);
      coefs.out_row <= cnt;
      coefs.out_mode <= mode_hold;
      coefs.last_row <= (cnt == ROW_W'(LAST_ROW));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt <= '0;
      coefs.valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (pop && q_row == ROW_W'(LAST_ROW)) begin
            state <= ST_EMIT;
            cnt <= '0;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            cnt <= cnt + 1'b1;
            if (cnt == ROW_W'(LAST_ROW)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
          cnt <= '0;
        end
      endcase
      if (out_load) begin
        coefs.valid <= 1'b1;
      end else if (coefs.ready) begin
        coefs.valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/integer_dct_residual_4x4.sv */
// 4x4 forward integer core transform of a prediction residual.
// rows: one word per block row, four current and four predicted pixels and
// a mode tag; the tag of a block's first row is kept for the whole block.
// coefs: four words per block, coefficient rows 0..3 of Y = C*D*C^T, each
// with its row index and the block's tag, last_row set on row 3.
// After the block's fourth row is taken into t, the coefficient rows leave
// through the output register, one per cycle while the receiver keeps up.
// The transform unit loads four rows from the row queue and then emits four
// coefficient rows before it loads the next block, so it takes no new rows
// from the queue while it emits.
// The front writes residual rows into a 4-deep queue, so it keeps taking rows
// while the transform unit emits or waits on the receiver.
// A stalled receiver holds the output register; the transform unit then
// stops, the queue fills and rows.ready drops.
// Reset (rst, synchronous) empties the queue, drops coefs.valid and starts a
// new block at row 0.
module integer_dct_residual_4x4 #(
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  idr_row_if.sink     rows,
  idr_coef_if.source  coefs
);
  import idr_pkg::*;

  localparam int QW = 4 * (PIXEL_BITS + 1) + ROW_W + MODE_W;

  logic [QW-1:0] f_data;
  logic          f_valid;
  logic          f_ready;
  logic [QW-1:0] b_data;
  logic          b_valid;
  logic          b_ready;

  idr_front #(.PIXEL_BITS(PIXEL_BITS), .QW(QW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows),
    .q_data  (f_data),
    .q_valid (f_valid),
    .q_ready (f_ready)
  );

  idr_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_data),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (b_data),
    .out_valid (b_valid),
    .out_ready (b_ready)
  );

  idr_back #(.PIXEL_BITS(PIXEL_BITS), .QW(QW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (b_data),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .coefs   (coefs)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import idr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_BLOCKS = 50;
  localparam int PLAN_ROWS = 20;

  // one block row: column j sits at index j
  typedef struct packed {
    logic [3:0][7:0]   cur;
    logic [3:0][7:0]   pred;
    logic [MODE_W-1:0] tag;
  } row_word_t;

  typedef struct packed {
    logic [3:0][COEF_W-1:0] coef;
    logic [ROW_W-1:0]       row;
    logic [MODE_W-1:0]      mode;
    logic                   last;
  } coef_word_t;

  typedef struct packed {
    row_word_t                w;
    logic                     typed;
    logic signed [COEF_W-1:0] dc;
    logic [MODE_W-1:0]        tmode;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst;
  // long receiver hold-offs requested so far, only the sender counts it up
  int   hold_reqs = 0;

  idr_row_if #(.PIXEL_BITS(8)) rows_if ();
  idr_coef_if coefs_if ();

  integer_dct_residual_4x4 #(.PIXEL_BITS(8)) dut (
    .clk   (clk),
    .rst   (rst),
    .rows  (rows_if),
    .coefs (coefs_if)
  );

  always #2 clk = ~clk;

  // transform state mirrored from the block
  int                core_m [4][4] = '{'{1, 1, 1, 1}, '{2, 1, -1, -2},
                                       '{1, -1, -1, 1}, '{1, -2, 2, -1}};
  int                resid [16];
  int                rows_in = 0;
  logic [MODE_W-1:0] held_tag = '0;

  coef_word_t  coef_rows_due [$];
  plan_entry_t plan [PLAN_ROWS];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          burst_left = 0;

  function automatic logic [COEF_W-1:0] clip_coef(input int v);
    if (v > COEF_MAX) v = COEF_MAX;
    if (v < COEF_MIN) v = COEF_MIN;
    return v[COEF_W-1:0];
  endfunction

  // stores the residual row; on the fourth row returns 1 and Y = C*D*C^T in y
  function automatic bit core_transform_row(input row_word_t w, output coef_word_t [3:0] y);
    int t [4][4];
    int i, j, k, s;
    y = '0;
    if (rows_in == 0) held_tag = w.tag;
    for (j = 0; j < 4; j++) resid[rows_in * 4 + j] = int'(w.cur[j]) - int'(w.pred[j]);
    if (rows_in != LAST_ROW) begin
      rows_in++;
      return 1'b0;
    end
    rows_in = 0;
    for (i = 0; i < 4; i++)
      for (j = 0; j < 4; j++) begin
        s = 0;
        for (k = 0; k < 4; k++) s += core_m[i][k] * resid[k * 4 + j];
        t[i][j] = s;
      end
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        s = 0;
        for (k = 0; k < 4; k++) s += t[i][k] * core_m[j][k];
        y[i].coef[j] = clip_coef(s);
      end
      y[i].row = ROW_W'(i);
      y[i].mode = held_tag;
      y[i].last = (i == LAST_ROW);
    end
    return 1'b1;
  endfunction

  function automatic row_word_t make_row(input logic [31:0] c, input logic [31:0] p,
                                         input logic [MODE_W-1:0] tag);
    row_word_t w;
    int j;
    for (j = 0; j < 4; j++) begin
      w.cur[j] = c[8 * j +: 8];
      w.pred[j] = p[8 * j +: 8];
    end
    w.tag = tag;
    return w;
  endfunction

  function automatic row_word_t random_row(input int kind, input bit first);
    row_word_t w;
    int j, v;
    for (j = 0; j < 4; j++) begin
      case (kind)
        0: begin
          w.cur[j] = 8'($urandom);
          w.pred[j] = 8'($urandom);
        end
        1: begin
          // small residuals around a random level
          w.cur[j] = 8'($urandom);
          v = int'(w.cur[j]) + $urandom_range(0, 16) - 8;
          w.pred[j] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        2: begin
          w.cur[j] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          w.pred[j] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        default: begin
          w.cur[j] = 8'($urandom);
          w.pred[j] = w.cur[j];
        end
      endcase
    end
    if (first && $urandom_range(0, 7) != 0) w.tag = MODE_W'($urandom_range(0, 9));
    else w.tag = MODE_W'($urandom_range(0, 15));
    return w;
  endfunction

  task automatic send_row(input row_word_t w);
    rows_if.valid <= 1'b1;
    rows_if.cur_0 <= w.cur[0];
    rows_if.cur_1 <= w.cur[1];
    rows_if.cur_2 <= w.cur[2];
    rows_if.cur_3 <= w.cur[3];
    rows_if.pred_0 <= w.pred[0];
    rows_if.pred_1 <= w.pred[1];
    rows_if.pred_2 <= w.pred[2];
    rows_if.pred_3 <= w.pred[3];
    rows_if.mode_tag <= w.tag;
    @(posedge clk);
    while (!rows_if.ready) @(posedge clk);
  endtask

  // bursts of words, then a random gap (none one time in four)
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rows_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    coef_word_t [3:0] y;
    row_word_t w;
    int i, k, b, r, kind;
    rst <= 1'b1;
    rows_if.valid <= 1'b0;
    rows_if.cur_0 <= '0;
    rows_if.cur_1 <= '0;
    rows_if.cur_2 <= '0;
    rows_if.cur_3 <= '0;
    rows_if.pred_0 <= '0;
    rows_if.pred_1 <= '0;
    rows_if.pred_2 <= '0;
    rows_if.pred_3 <= '0;
    rows_if.mode_tag <= '0;

    // flat block, full positive and negative dc (tags mixed), max ac checkerboard,
    // alternating bit patterns
    for (i = 0; i < 4; i++) begin
      plan[i] = '{w: make_row(32'h80808080, 32'h80808080, 4'd0),
                  typed: (i == 3), dc: 15'sd0, tmode: 4'd0};
      plan[4 + i] = '{w: make_row(32'hFFFFFFFF, 32'h00000000, 4'd9),
                      typed: (i == 3), dc: 15'sd4080, tmode: 4'd9};
      plan[8 + i] = '{w: make_row(32'h00000000, 32'hFFFFFFFF, 4'(i == 0 ? 15 : 4 * i - 2)),
                      typed: (i == 3), dc: -15'sd4080, tmode: 4'd15};
      plan[12 + i] = '{w: make_row(i < 2 ? 32'h0000FFFF : 32'hFFFF0000,
                                   i < 2 ? 32'hFFFF0000 : 32'h0000FFFF, 4'(i * 5 + 3)),
                       typed: 1'b0, dc: 15'sd0, tmode: 4'd0};
      plan[16 + i] = '{w: make_row(i[0] ? 32'h55AA55AA : 32'hAA55AA55,
                                   i[0] ? 32'hAA55AA55 : 32'h55AA55AA, 4'(i + 6)),
                       typed: 1'b0, dc: 15'sd0, tmode: 4'd0};
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_ROWS; i++) begin
      send_row(plan[i].w);
      if (core_transform_row(plan[i].w, y)) begin
        for (k = 0; k < 4; k++) begin
          if (plan[i].typed) begin
            y[k].coef = '0;
            if (k == 0) y[k].coef[0] = plan[i].dc;
            y[k].mode = plan[i].tmode;
          end
          coef_rows_due.push_back(y[k]);
        end
      end
      pace();
    end

    hold_reqs++;
    for (b = 0; b < RANDOM_BLOCKS; b++) begin
      kind = $urandom_range(0, 5);
      if (kind > 3) kind = 0;
      if (b == RANDOM_BLOCKS / 2) hold_reqs++;
      for (r = 0; r < 4; r++) begin
        w = random_row(kind, r == 0);
        send_row(w);
        if (core_transform_row(w, y))
          for (k = 0; k < 4; k++) coef_rows_due.push_back(y[k]);
        pace();
      end
    end
    rows_if.valid <= 1'b0;

    while (coef_rows_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && coef_rows_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: a stall style picked anew each time the phase counter wraps, long hold-offs on request
  initial begin
    int style, phase, hold_left, holds_taken;
    style = 0;
    phase = 0;
    hold_left = 0;
    holds_taken = 0;
    coefs_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != hold_reqs) begin
        holds_taken = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (phase == 0) style = $urandom_range(0, 3);
      phase = (phase + 1) % 48;
      if (hold_left > 0) begin
        hold_left--;
        coefs_if.ready <= 1'b0;
      end else begin
        case (style)
          0: coefs_if.ready <= 1'b1;
          1: coefs_if.ready <= 1'($urandom_range(0, 1));
          2: coefs_if.ready <= (phase % 4 == 0);
          default: coefs_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    coef_word_t got, want;
    bit bad;
    int j;
    if (!rst) begin
      if (coefs_if.valid && coefs_if.ready) begin
        got.coef[0] = coefs_if.coef_0;
        got.coef[1] = coefs_if.coef_1;
        got.coef[2] = coefs_if.coef_2;
        got.coef[3] = coefs_if.coef_3;
        got.row = coefs_if.out_row;
        got.mode = coefs_if.out_mode;
        got.last = coefs_if.last_row;
        if (coef_rows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected coef word: row %0d mode %0d coefs %0d %0d %0d %0d",
                     got.row, got.mode, $signed(got.coef[0]), $signed(got.coef[1]),
                     $signed(got.coef[2]), $signed(got.coef[3]));
        end else begin
          want = coef_rows_due.pop_front();
          bad = (got.row != want.row) || (got.mode != want.mode) || (got.last != want.last);
          for (j = 0; j < 4; j++) if (got.coef[j] != want.coef[j]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("coef word mismatch at %0t", $realtime);
              $display("  expected row %0d mode %0d last %0d coefs %0d %0d %0d %0d",
                       want.row, want.mode, want.last, $signed(want.coef[0]),
                       $signed(want.coef[1]), $signed(want.coef[2]), $signed(want.coef[3]));
              $display("  actual   row %0d mode %0d last %0d coefs %0d %0d %0d %0d",
                       got.row, got.mode, got.last, $signed(got.coef[0]),
                       $signed(got.coef[1]), $signed(got.coef[2]), $signed(got.coef[3]));
            end
          end
        end
      end
      if ((coefs_if.valid && coefs_if.ready) || (rows_if.valid && rows_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

endmodule

/* sim.f */
hdl/idr_pkg.sv
hdl/idr_row_if.sv
hdl/idr_coef_if.sv
hdl/idr_front.sv
hdl/idr_queue.sv
hdl/idr_back.sv
hdl/integer_dct_residual_4x4.sv
sim/testbench.sv
